// ----- rtl/ljvs_pkg.sv -----
// Shared types, register indexes and fixed-point helpers for the LJ Verlet step block.
`timescale 1ns / 1ps
package ljvs_pkg;

    typedef logic signed [31:0] t_word;

    // One particle as held by a ring cell: axis 0 is x, 1 is y, 2 is z
    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] prev;
        logic [2:0][31:0] frc;
    } t_part;

    typedef struct packed {
        logic load;
        logic shift;
        logic fwr;
        logic upd;
    } t_cell_ctl;

    localparam logic [2:0] CFG_ACTIVE = 3'd0;
    localparam logic [2:0] CFG_BOX    = 3'd1;
    localparam logic [2:0] CFG_CUT    = 3'd2;
    localparam logic [2:0] CFG_DTSQ   = 3'd3;
    localparam logic [2:0] CFG_INV2DT = 3'd4;

    localparam logic [30:0] MAX31 = '1;

    function automatic t_word sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // single conditional correction by one box length
    function automatic logic signed [39:0] wrap40(input logic signed [39:0] v,
                                                 input logic [30:0] box);
        logic signed [39:0] half;
        logic signed [39:0] bx;
        half = $signed({9'd0, box >> 1});
        bx   = $signed({9'd0, box});
        if (v > half) return v - bx;
        if (v < -half) return v + bx;
        return v;
    endfunction

    function automatic logic [30:0] qmul(input logic [30:0] a, input logic [30:0] b);
        logic [61:0] p;
        p = a * b;
        if (p[61:16] > {15'd0, MAX31}) return MAX31;
        return p[46:16];
    endfunction

endpackage

// ----- rtl/ljvs_cell.sv -----
// Ring cell: holds one particle's position, previous position and force.
`timescale 1ns / 1ps
module ljvs_cell
    import ljvs_pkg::*;
(
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  t_part            i_nb,
    input  t_part            i_ld,
    input  logic [2:0][31:0] i_frc,
    input  logic [2:0][31:0] i_new,
    output t_part            o_part
);

    t_part r_part;

    always_ff @(posedge i_clk) begin
        priority if (i_ctl.load) begin
            r_part.pos  <= i_ld.pos;
            r_part.prev <= i_ld.prev;
        end else if (i_ctl.shift) begin
            r_part <= i_nb;
        end else if (i_ctl.fwr) begin
            r_part.frc <= i_frc;
        end else if (i_ctl.upd) begin
            r_part.prev <= r_part.pos;
            r_part.pos  <= i_new;
        end
    end

    assign o_part = r_part;

endmodule

// ----- rtl/ljvs_div.sv -----
// Restoring divider: 2^32 / den, one quotient bit per cycle.
`timescale 1ns / 1ps
module ljvs_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [30:0] i_den,
    output logic        o_done,
    output logic [32:0] o_quo
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [31:0] r_rem;
    logic [32:0] r_quo;
    logic [30:0] r_den;
    logic [32:0] n_shift;
    logic        n_ge;
    logic [32:0] n_rem;

    // dividend has only its top bit set
    always_comb begin
        n_shift = {r_rem, (r_cnt == 6'd32)};
        n_ge    = n_shift >= {2'b00, r_den};
        n_rem   = n_ge ? n_shift - {2'b00, r_den} : n_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 6'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem[31:0];
            r_quo <= {r_quo[31:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ----- rtl/lj_force_verlet_step_top.sv -----
// Top level: particle ring, pair force sequencer and Verlet update.
`timescale 1ns / 1ps
// Lennard-Jones step engine. Particles live in a ring of cells that rotates
// one place per visit, so the sequencer always sees the visited particle at
// cell 0. A load request writes one cell directly. A step request with n active
// particles visits n*n cell positions: the self slot is skipped, a pair outside
// the cutoff needs only its squared distance, and a pair inside it also needs
// a reciprocal, which the divider supplies unless the distance is zero (the
// divider dominates). Each particle's forces are then stored, and each result
// is computed per axis and held until it is taken.
module lj_force_verlet_step_top
    import ljvs_pkg::*;
#(
    parameter int MAX_PARTICLES = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_opcode,
    input  logic [5:0]         i_index,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_prev_x,
    input  logic signed [31:0] i_prev_y,
    input  logic signed [31:0] i_prev_z,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [5:0]         o_slot,
    output logic signed [31:0] o_new_x,
    output logic signed [31:0] o_new_y,
    output logic signed [31:0] o_new_z,
    output logic signed [31:0] o_vel_x,
    output logic signed [31:0] o_vel_y,
    output logic signed [31:0] o_vel_z,
    output logic               o_last,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_addr,
    input  logic [30:0]        i_cfg_wdata
);

    localparam int CW = $clog2(MAX_PARTICLES + 1);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_SWEEP = 5'd1;
    localparam logic [4:0] S_SQ    = 5'd2;
    localparam logic [4:0] S_CMP   = 5'd3;
    localparam logic [4:0] S_DIV   = 5'd4;
    localparam logic [4:0] S_P2    = 5'd5;
    localparam logic [4:0] S_P3    = 5'd6;
    localparam logic [4:0] S_P4    = 5'd7;
    localparam logic [4:0] S_P7    = 5'd8;
    localparam logic [4:0] S_FAC   = 5'd9;
    localparam logic [4:0] S_ACC   = 5'd10;
    localparam logic [4:0] S_NEXTJ = 5'd11;
    localparam logic [4:0] S_FWR   = 5'd12;
    localparam logic [4:0] S_U1    = 5'd13;
    localparam logic [4:0] S_U2    = 5'd14;
    localparam logic [4:0] S_OUT   = 5'd15;
    localparam logic [4:0] S_ROT   = 5'd16;

    // configuration
    logic [6:0]  r_active;
    logic [30:0] r_box;
    logic [30:0] r_cut;
    logic [16:0] r_dtsq;
    logic [30:0] r_inv2dt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 7'd32;
            r_box    <= 31'd655360;
            r_cut    <= 31'd409600;
            r_dtsq   <= 17'd1;
            r_inv2dt <= 31'd65536000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_ACTIVE: r_active <= i_cfg_wdata[6:0];
                CFG_BOX:    r_box    <= i_cfg_wdata;
                CFG_CUT:    r_cut    <= i_cfg_wdata;
                CFG_DTSQ:   r_dtsq   <= i_cfg_wdata[16:0];
                CFG_INV2DT: r_inv2dt <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [4:0]         r_state;
    logic [CW-1:0]      r_n;
    logic [CW-1:0]      r_i;
    logic [CW-1:0]      r_j;
    logic [1:0]         r_a;
    logic [2:0][31:0]   r_xi;
    logic [2:0][31:0]   r_xnx;
    logic signed [31:0] r_d [3];
    logic [47:0]        r_r2;
    logic [30:0]        r_inv;
    logic [30:0]        r_inv2;
    logic [30:0]        r_inv3;
    logic [30:0]        r_inv4;
    logic [30:0]        r_inv7;
    logic signed [31:0] r_fac;
    logic signed [31:0] r_f [3];
    logic [2:0][31:0]   r_nw;
    logic [2:0][31:0]   r_vel;
    logic               r_ov;
    logic               r_last;

    t_part            w_part [MAX_PARTICLES];
    t_part            w_nb   [MAX_PARTICLES];
    t_cell_ctl        w_ctl  [MAX_PARTICLES];
    t_part            w_c0;
    t_part            w_ld;
    logic [2:0][31:0] w_frc;
    logic             w_in_acc;
    logic [CW-1:0]    w_ncl;

    assign w_c0      = w_part[0];
    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_ncl     = (r_active > 7'(MAX_PARTICLES)) ? CW'(MAX_PARTICLES) : CW'(r_active);
    assign w_ld.pos  = {i_pos_z, i_pos_y, i_pos_x};
    assign w_ld.prev = {i_prev_z, i_prev_y, i_prev_x};
    assign w_ld.frc  = '0;
    assign w_frc     = {r_f[2], r_f[1], r_f[0]};

    genvar k;
    generate
        for (k = 0; k < MAX_PARTICLES; k++) begin : g_cell
            if (k == MAX_PARTICLES - 1) begin : g_end
                assign w_nb[k] = w_part[0];
            end else begin : g_mid
                assign w_nb[k] = (CW'(k) == r_n - CW'(1)) ? w_part[0] : w_part[k+1];
            end
            assign w_ctl[k].load  = w_in_acc && !i_opcode && (i_index == 6'(k));
            assign w_ctl[k].shift = ((r_state == S_NEXTJ) || (r_state == S_ROT))
                                    && (CW'(k) < r_n);
            assign w_ctl[k].fwr   = (r_state == S_FWR) && (r_i == CW'(k));
            assign w_ctl[k].upd   = (k == 0) && (r_state == S_OUT) && i_out_ready;

            ljvs_cell u_cell (
                .i_clk  (i_clk),
                .i_ctl  (w_ctl[k]),
                .i_nb   (w_nb[k]),
                .i_ld   (w_ld),
                .i_frc  (w_frc),
                .i_new  (r_nw),
                .o_part (w_part[k])
            );
        end
    endgenerate

    // reciprocal unit
    logic        w_div_start;
    logic        w_div_done;
    logic [32:0] w_quo;
    logic [30:0] w_r2s;

    assign w_r2s       = (r_r2 > {17'd0, MAX31}) ? MAX31 : r_r2[30:0];
    assign w_div_start = (r_state == S_CMP) && (w_r2s < r_cut) && (w_r2s != 31'd0);

    ljvs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_den   (w_r2s),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // datapath
    logic signed [31:0] w_dn [3];
    logic signed [63:0] w_sq;
    logic signed [39:0] w_s7;
    logic signed [39:0] w_s4;
    logic signed [63:0] w_df;
    logic signed [63:0] w_fsum;
    logic signed [63:0] w_acc;
    logic signed [63:0] w_sum;
    logic signed [31:0] w_nwv;
    logic signed [31:0] w_diff;
    logic signed [63:0] w_vp;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_dn[a] = sat32(64'(wrap40(40'($signed(r_xi[a])) - 40'($signed(w_c0.pos[a])),
                                       r_box)));
        end
        w_sq   = r_d[r_a] * r_d[r_a];
        w_s7   = $signed({9'd0, r_inv7});
        w_s4   = $signed({9'd0, r_inv4});
        w_df   = 64'(r_d[r_a]) * 64'(r_fac);
        w_fsum = 64'(r_f[r_a]) + (w_df >>> 16);
        w_acc  = (64'($signed(w_c0.frc[r_a])) * $signed({47'd0, r_dtsq})) >>> 16;
        w_sum  = 64'($signed(w_c0.pos[r_a])) * 64'sd2 - 64'($signed(w_c0.prev[r_a])) + w_acc;
        w_nwv  = sat32(64'(wrap40(w_sum[39:0], r_box)));
        w_diff = sat32(64'(wrap40(40'($signed(r_nw[r_a])) - 40'($signed(w_c0.prev[r_a])),
                                  r_box)));
        w_vp   = 64'(w_diff) * $signed({33'd0, r_inv2dt});
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_n     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_a     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc && i_opcode) begin
                        r_n <= w_ncl;
                        r_i <= '0;
                        r_j <= '0;
                        if (w_ncl != '0) r_state <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    r_a <= '0;
                    if (r_j == r_i) r_state <= S_NEXTJ;
                    else r_state <= S_SQ;
                end
                S_SQ: begin
                    if (r_a == 2'd2) begin
                        r_a     <= '0;
                        r_state <= S_CMP;
                    end else begin
                        r_a <= r_a + 2'd1;
                    end
                end
                S_CMP: begin
                    if (w_r2s >= r_cut) r_state <= S_NEXTJ;
                    else if (w_r2s == 31'd0) r_state <= S_P2;
                    else r_state <= S_DIV;
                end
                S_DIV:  if (w_div_done) r_state <= S_P2;
                S_P2:   r_state <= S_P3;
                S_P3:   r_state <= S_P4;
                S_P4:   r_state <= S_P7;
                S_P7:   r_state <= S_FAC;
                S_FAC:  r_state <= S_ACC;
                S_ACC: begin
                    if (r_a == 2'd2) begin
                        r_a     <= '0;
                        r_state <= S_NEXTJ;
                    end else begin
                        r_a <= r_a + 2'd1;
                    end
                end
                S_NEXTJ: begin
                    r_j <= r_j + CW'(1);
                    if (r_j == r_n - CW'(1)) r_state <= S_FWR;
                    else r_state <= S_SWEEP;
                end
                S_FWR: begin
                    r_j <= '0;
                    r_a <= '0;
                    if (r_i == r_n - CW'(1)) begin
                        r_i     <= '0;
                        r_state <= S_U1;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_SWEEP;
                    end
                end
                S_U1: begin
                    if (r_a == 2'd2) begin
                        r_a     <= '0;
                        r_state <= S_U2;
                    end else begin
                        r_a <= r_a + 2'd1;
                    end
                end
                S_U2: begin
                    if (r_a == 2'd2) begin
                        r_a     <= '0;
                        r_ov    <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_a <= r_a + 2'd1;
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_ov    <= 1'b0;
                        r_state <= S_ROT;
                    end
                end
                S_ROT: begin
                    if (r_i == r_n - CW'(1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_U1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_xi <= w_c0.pos;
                for (int a = 0; a < 3; a++) r_f[a] <= '0;
            end
            S_SWEEP: begin
                // next row's own position passes by during this row
                if (r_j == CW'(r_i + CW'(1))) r_xnx <= w_c0.pos;
                for (int a = 0; a < 3; a++) r_d[a] <= w_dn[a];
                r_r2 <= '0;
            end
            S_SQ:  r_r2 <= r_r2 + w_sq[63:16];
            S_CMP: if (w_r2s == 31'd0) r_inv <= MAX31;
            S_DIV: if (w_div_done) r_inv <= (w_quo > {2'd0, MAX31}) ? MAX31 : w_quo[30:0];
            S_P2:  r_inv2 <= qmul(r_inv, r_inv);
            S_P3:  r_inv3 <= qmul(r_inv2, r_inv);
            S_P4:  r_inv4 <= qmul(r_inv2, r_inv2);
            S_P7:  r_inv7 <= qmul(r_inv4, r_inv3);
            S_FAC: r_fac <= sat32(64'(w_s7 * 40'sd48 - w_s4 * 40'sd24));
            S_ACC: r_f[r_a] <= sat32(w_fsum);
            S_FWR: begin
                r_xi <= r_xnx;
                for (int a = 0; a < 3; a++) r_f[a] <= '0;
            end
            S_U1:  r_nw[r_a] <= w_nwv;
            S_U2: begin
                r_vel[r_a] <= sat32(w_vp >>> 16);
                r_last     <= (r_i == r_n - CW'(1));
            end
            default: ;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_slot      = 6'(r_i);
    assign o_new_x     = r_nw[0];
    assign o_new_y     = r_nw[1];
    assign o_new_z     = r_nw[2];
    assign o_vel_x     = r_vel[0];
    assign o_vel_y     = r_vel[1];
    assign o_vel_z     = r_vel[2];
    assign o_last      = r_last;

endmodule

// ----- rtl/ljvs_check.sv -----
// Port-level checks for the LJ Verlet step block, bound to the top level.
`timescale 1ns / 1ps
module ljvs_check (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [5:0] o_slot
);

    // a waiting result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_slot))
        else $error("result changed while stalled");

    // no new request is taken while a result waits
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while result pending");

    // each result is shown once
    a_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready |=> !o_out_valid)
        else $error("result repeated");

endmodule

bind lj_force_verlet_step_top ljvs_check u_chk (.*);
